### rtl/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants of the dense matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pkg;

    localparam int IDX_W      = 4;
    localparam int SIZE_W     = 5;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int IDX_REACH  = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [1:0] REQ_WR_A    = 2'd0;
    localparam logic [1:0] REQ_WR_B    = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [IDX_W-1:0]         k;
        logic signed [ELEM_W-1:0] a;
    } t_tok;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } t_res;

endpackage

`default_nettype wire

### rtl/dmm_cell.sv
// ----------------------------------------------------------------------------
// dmm_cell
// One column cell: holds a column of B, multiplies each passing A element
// by its B element and accumulates the dot product of that column.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_cell #(
    parameter int CELL_IDX = 0,
    parameter int DEPTH    = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire dmm_pkg::t_tok                    i_tok,
    input  wire logic                             i_pass,
    input  wire logic                             i_b_we,
    input  wire logic [dmm_pkg::IDX_W-1:0]        i_b_row,
    input  wire logic [dmm_pkg::IDX_W-1:0]        i_b_col,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0] i_b_data,
    output dmm_pkg::t_tok                         o_tok,
    output dmm_pkg::t_res                         o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [dmm_pkg::ELEM_W-1:0] r_mem [DEPTH];
    logic signed [dmm_pkg::ELEM_W-1:0] r_b;
    dmm_pkg::t_tok                     r_tok1;
    logic                              r_p_valid;
    logic                              r_p_first;
    logic                              r_p_last;
    logic signed [dmm_pkg::PROD_W-1:0] r_prod;
    logic signed [dmm_pkg::ACC_W-1:0]  r_acc;
    logic signed [dmm_pkg::ACC_W-1:0]  n_acc;
    logic                              r_done;
    logic signed [dmm_pkg::ACC_W-1:0]  w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_b_we && i_b_col == dmm_pkg::IDX_W'(CELL_IDX)) begin
            r_mem[i_b_row[IW-1:0]] <= i_b_data;
        end
        r_b <= r_mem[i_tok.k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1    <= '0;
            r_p_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_tok1    <= i_tok;
            r_p_valid <= r_tok1.valid;
            r_done    <= r_p_valid & r_p_last;
        end
    end

    assign w_prod_ext = {{(dmm_pkg::ACC_W-dmm_pkg::PROD_W){r_prod[dmm_pkg::PROD_W-1]}}, r_prod};

    always_comb begin
        n_acc = r_acc;
        if (r_p_valid) begin
            n_acc = r_p_first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_first <= r_tok1.first;
        r_p_last  <= r_tok1.last;
        r_prod    <= r_tok1.a * r_b;
        r_acc     <= n_acc;
    end

    // drop the beat at the neighbor when the next column is not in use
    always_comb begin
        o_tok       = r_tok1;
        o_tok.valid = r_tok1.valid & i_pass;
    end

    assign o_res.done = r_done;
    assign o_res.acc  = r_acc;

endmodule

`default_nettype wire

### rtl/dmm_seq.sv
// ----------------------------------------------------------------------------
// dmm_seq
// Row sequencer: holds matrix A and streams one row of it, one element per
// cycle, into the head of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dmm_seq #(
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_a_we,
    input  wire logic [dmm_pkg::IDX_W-1:0]         i_a_row,
    input  wire logic [dmm_pkg::IDX_W-1:0]         i_a_col,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0] i_a_data,
    input  wire logic                              i_go,
    input  wire logic [dmm_pkg::IDX_W-1:0]         i_go_row,
    input  wire logic [dmm_pkg::SIZE_W-1:0]        i_n,
    input  wire logic                              i_row_done,
    output logic                                   o_busy,
    output logic [dmm_pkg::IDX_W-1:0]              o_row,
    output dmm_pkg::t_tok                          o_tok
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH * DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    logic signed [dmm_pkg::ELEM_W-1:0] r_mem [DEPTH * DEPTH];
    logic signed [dmm_pkg::ELEM_W-1:0] r_a_rd;
    t_state                            r_state;
    t_state                            n_state;
    logic [dmm_pkg::IDX_W-1:0]         r_k;
    logic [dmm_pkg::IDX_W-1:0]         n_k;
    logic [dmm_pkg::IDX_W-1:0]         r_row;
    logic [dmm_pkg::IDX_W-1:0]         n_row;
    logic                              r_feed_valid;
    logic                              r_feed_first;
    logic                              r_feed_last;
    logic [dmm_pkg::IDX_W-1:0]         r_feed_k;
    logic [AW-1:0]                     w_wr_addr;
    logic [AW-1:0]                     w_rd_addr;
    logic                              w_k_last;

    assign w_wr_addr = AW'(i_a_row[IW-1:0]) * AW'(DEPTH) + AW'(i_a_col[IW-1:0]);
    assign w_rd_addr = AW'(r_row[IW-1:0]) * AW'(DEPTH) + AW'(r_k[IW-1:0]);
    assign w_k_last  = (dmm_pkg::SIZE_W'(r_k) + 5'd1) == i_n;

    always_ff @(posedge i_clk) begin
        if (i_a_we) begin
            r_mem[w_wr_addr] <= i_a_data;
        end
        r_a_rd <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_row   = r_row;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_row   = i_go_row;
                end
            end
            S_RUN: begin
                n_k = r_k + 4'd1;
                if (w_k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_row_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_feed_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_feed_valid <= (r_state == S_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_feed_k     <= r_k;
        r_feed_first <= (r_k == '0);
        r_feed_last  <= w_k_last;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_row       = r_row;
    assign o_tok.valid = r_feed_valid;
    assign o_tok.first = r_feed_first;
    assign o_tok.last  = r_feed_last;
    assign o_tok.k     = r_feed_k;
    assign o_tok.a     = r_a_rd;

endmodule

`default_nettype wire

### rtl/dense_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// Square matrix product engine on signed Q8.8 elements with Q32.16 results.
// ----------------------------------------------------------------------------
// Write beats load one element of A or B; busy stays low. A compute beat
// raises busy and streams row r of A, one element per cycle, through a chain
// of column cells that each hold one column of B. Column c finishes in the
// cycle after column c-1, so the n results of the row leave one per cycle in
// column order. Cells past column n-1 are not fed. Busy falls at the edge that
// takes the last result, so a new compute beat is accepted only once the last
// result of the previous row has left. Each result shows on the result ports
// for exactly one cycle with o_result_strobe high; the receiver cannot stall
// it. Write matrix_size only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_multiply_core #(
    parameter int MAX_SIZE = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [1:0]                        i_req_type,
    input  wire logic [dmm_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [dmm_pkg::IDX_W-1:0]         i_col_index,
    input  wire logic signed [dmm_pkg::ELEM_W-1:0] i_element_value,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [dmm_pkg::SIZE_W-1:0]        i_cfg_wr_data,
    output logic                                   o_result_strobe,
    output logic [dmm_pkg::IDX_W-1:0]              o_out_row,
    output logic [dmm_pkg::IDX_W-1:0]              o_out_col,
    output logic signed [dmm_pkg::ACC_W-1:0]       o_product_sum,
    output logic                                   o_last_in_row
);

    localparam int NCELL = (MAX_SIZE < dmm_pkg::IDX_REACH) ? MAX_SIZE : dmm_pkg::IDX_REACH;
    localparam logic [dmm_pkg::SIZE_W-1:0] N_CAP = dmm_pkg::SIZE_W'(NCELL);

    logic [dmm_pkg::SIZE_W-1:0]        r_matrix_size;
    logic [dmm_pkg::SIZE_W-1:0]        w_n;
    logic                              w_busy;
    logic                              w_accept;
    logic                              w_wr_ok;
    logic                              w_a_we;
    logic                              w_b_we;
    logic                              w_go;
    logic [dmm_pkg::IDX_W-1:0]         w_row;
    dmm_pkg::t_tok                     w_tok [NCELL+1];
    dmm_pkg::t_res                     w_res [NCELL];
    logic                              w_sel_any;
    logic [dmm_pkg::IDX_W-1:0]         w_sel_col;
    logic signed [dmm_pkg::ACC_W-1:0]  w_sel_sum;
    logic                              w_sel_last;
    logic                              r_out_valid;
    logic [dmm_pkg::IDX_W-1:0]         r_out_col;
    logic [dmm_pkg::IDX_W-1:0]         r_out_row;
    logic signed [dmm_pkg::ACC_W-1:0]  r_out_sum;
    logic                              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= dmm_pkg::SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_matrix_size <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_n = r_matrix_size;
        if (r_matrix_size == '0) begin
            w_n = 5'd1;
        end else if (r_matrix_size > N_CAP) begin
            w_n = N_CAP;
        end
    end

    assign w_accept = i_start & ~w_busy;
    assign w_wr_ok  = (dmm_pkg::SIZE_W'(i_row_index) < N_CAP)
                    & (dmm_pkg::SIZE_W'(i_col_index) < N_CAP);

    always_comb begin
        w_a_we = 1'b0;
        w_b_we = 1'b0;
        w_go   = 1'b0;
        case (i_req_type)
            dmm_pkg::REQ_WR_A: begin
                w_a_we = w_accept & w_wr_ok;
            end
            dmm_pkg::REQ_WR_B: begin
                w_b_we = w_accept & w_wr_ok;
            end
            dmm_pkg::REQ_COMPUTE: begin
                w_go = w_accept & (dmm_pkg::SIZE_W'(i_row_index) < w_n);
            end
            default: begin
                w_go = 1'b0;
            end
        endcase
    end

    dmm_seq #(
        .DEPTH (NCELL)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_a_we     (w_a_we),
        .i_a_row    (i_row_index),
        .i_a_col    (i_col_index),
        .i_a_data   (i_element_value),
        .i_go       (w_go),
        .i_go_row   (i_row_index),
        .i_n        (w_n),
        .i_row_done (r_out_valid & r_out_last),
        .o_busy     (w_busy),
        .o_row      (w_row),
        .o_tok      (w_tok[0])
    );

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        dmm_cell #(
            .CELL_IDX (c),
            .DEPTH    (NCELL)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[c]),
            .i_pass   (dmm_pkg::SIZE_W'(c + 1) < w_n),
            .i_b_we   (w_b_we),
            .i_b_row  (i_row_index),
            .i_b_col  (i_col_index),
            .i_b_data (i_element_value),
            .o_tok    (w_tok[c+1]),
            .o_res    (w_res[c])
        );
    end

    always_comb begin
        w_sel_any  = 1'b0;
        w_sel_col  = '0;
        w_sel_sum  = '0;
        w_sel_last = 1'b0;
        for (int c = 0; c < NCELL; c++) begin
            if (w_res[c].done && (dmm_pkg::SIZE_W'(c) < w_n)) begin
                w_sel_any  = 1'b1;
                w_sel_col  = dmm_pkg::IDX_W'(c);
                w_sel_sum  = w_sel_sum | w_res[c].acc;
                w_sel_last = (dmm_pkg::SIZE_W'(c) + 5'd1) == w_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_out_valid <= w_sel_any;
            r_out_last  <= w_sel_any & w_sel_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_col <= w_sel_col;
        r_out_row <= w_row;
        r_out_sum <= w_sel_sum;
    end

    assign o_busy          = w_busy;
    assign o_result_strobe = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_sum   = r_out_sum;
    assign o_last_in_row   = r_out_last;

endmodule

`default_nettype wire
